// File: sv/ipsp_pkg.sv
`timescale 1ns / 1ps

package ipsp_pkg;

    // result kinds
    localparam logic [2:0] K_WRITE     = 3'd0;
    localparam logic [2:0] K_FILL      = 3'd1;
    localparam logic [2:0] K_DONE      = 3'd2;
    localparam logic [2:0] K_TRUNC     = 3'd3;
    localparam logic [2:0] K_BAD_MAGIC = 3'd4;
    localparam logic [2:0] K_EARLY     = 3'd5;

    localparam logic [23:0] EOF_MARK   = 24'h454F46;
    localparam logic [2:0]  MAGIC_LAST = 3'd4;

    typedef struct packed {
        logic [7:0] patch_byte;
        logic       final_byte;
    } t_ipsp_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [15:0] run_length;
        logic [7:0]  data_value;
    } t_ipsp_out;

    // command handed from the parser to the result stage
    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] offset;
        logic [15:0] index;
        logic [15:0] run_length;
        logic [7:0]  data_value;
    } t_ipsp_cmd;

    // "PATCH"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/ips_patch_stream_parser.sv
`timescale 1ns / 1ps
// a result caused by an accepted byte is written into the command queue and then registered in the output register
// throughput: one patch byte per cycle; the parser holds o_in_stall only while
//   the QUEUE_DEPTH-entry command queue is full, which needs a stalled output
// reset: synchronous, active low; the parser returns to expecting the magic and
//   the queue and output register are emptied, with no clearing pass
module ips_patch_stream_parser import ipsp_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_ipsp_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_ipsp_out o_out_data
);

    logic      accept;
    logic      push;
    t_ipsp_cmd push_cmd;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    t_ipsp_cmd pop_cmd;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    ipsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ipsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (q_empty)
    );

    ipsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (pop_cmd),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (o_out_data)
    );

endmodule

// File: sv/ipsp_front.sv
`timescale 1ns / 1ps

module ipsp_front import ipsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_ipsp_in  i_item,
    output logic      o_push,
    output t_ipsp_cmd o_cmd
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_OFFSET,
        PH_LENGTH,
        PH_DATA,
        PH_RUNCOUNT,
        PH_RUNVALUE,
        PH_TRAILER,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [23:0] r_offset, n_offset;
    logic [15:0] r_length, n_length;
    logic [23:0] r_tsize, n_tsize;
    logic [1:0]  r_tcount, n_tcount;

    logic        early;
    logic        restart;
    logic [16:0] count_inc;
    logic [7:0]  b;
    logic        fin;

    assign b         = i_item.patch_byte;
    assign fin       = i_item.final_byte;
    assign count_inc = {1'b0, r_count} + 17'd1;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_offset = r_offset;
        n_length = r_length;
        n_tsize  = r_tsize;
        n_tcount = r_tcount;
        o_push   = 1'b0;
        o_cmd    = '0;
        early    = 1'b0;
        restart  = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_MAGIC: begin
                    if (b != magic_byte(r_count[2:0])) begin
                        o_push     = 1'b1;
                        o_cmd.kind = K_BAD_MAGIC;
                        if (fin) begin
                            restart = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_count = count_inc[15:0];
                        if (r_count[2:0] == MAGIC_LAST) begin
                            n_count = '0;
                            n_phase = PH_OFFSET;
                        end
                        early = fin;
                    end
                end
                PH_OFFSET: begin
                    n_offset = {r_offset[15:0], b};
                    n_count  = count_inc[15:0];
                    if (r_count == 16'd2) begin
                        n_count = '0;
                        if (n_offset == EOF_MARK) begin
                            if (fin) begin
                                o_push     = 1'b1;
                                o_cmd.kind = K_DONE;
                                restart    = 1'b1;
                            end else begin
                                n_phase  = PH_TRAILER;
                                n_tsize  = '0;
                                n_tcount = '0;
                            end
                        end else begin
                            n_phase = PH_LENGTH;
                            early   = fin;
                        end
                    end else begin
                        early = fin;
                    end
                end
                PH_LENGTH: begin
                    n_length = {r_length[7:0], b};
                    n_count  = count_inc[15:0];
                    if (r_count == 16'd1) begin
                        n_count = '0;
                        n_phase = (n_length != '0) ? PH_DATA : PH_RUNCOUNT;
                    end
                    early = fin;
                end
                PH_DATA: begin
                    if (fin) begin
                        early = 1'b1;
                    end else begin
                        o_push           = 1'b1;
                        o_cmd.kind       = K_WRITE;
                        o_cmd.offset     = r_offset;
                        o_cmd.index      = r_count;
                        o_cmd.data_value = b;
                        n_count          = count_inc[15:0];
                        if (count_inc >= {1'b0, r_length}) begin
                            n_count = '0;
                            n_phase = PH_OFFSET;
                        end
                    end
                end
                PH_RUNCOUNT: begin
                    n_length = {r_length[7:0], b};
                    n_count  = count_inc[15:0];
                    if (r_count == 16'd1) begin
                        n_count = '0;
                        n_phase = PH_RUNVALUE;
                    end
                    early = fin;
                end
                PH_RUNVALUE: begin
                    if (fin) begin
                        early = 1'b1;
                    end else begin
                        o_push           = 1'b1;
                        o_cmd.kind       = K_FILL;
                        o_cmd.offset     = r_offset;
                        o_cmd.run_length = r_length;
                        o_cmd.data_value = b;
                        n_count          = '0;
                        n_phase          = PH_OFFSET;
                    end
                end
                PH_TRAILER: begin
                    if (r_tcount != 2'd3) begin
                        n_tsize  = {r_tsize[15:0], b};
                        n_tcount = r_tcount + 2'd1;
                    end
                    if (fin) begin
                        o_push  = 1'b1;
                        restart = 1'b1;
                        if (n_tcount == 2'd3) begin
                            o_cmd.kind   = K_TRUNC;
                            o_cmd.offset = n_tsize;
                        end else begin
                            o_cmd.kind = K_DONE;
                        end
                    end
                end
                PH_SKIP: begin
                    restart = fin;
                end
                default: begin
                    restart = 1'b1;
                end
            endcase
            if (early) begin
                o_push     = 1'b1;
                o_cmd      = '0;
                o_cmd.kind = K_EARLY;
                restart    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_phase  <= PH_MAGIC;
            r_count  <= '0;
            r_offset <= '0;
            r_length <= '0;
            r_tsize  <= '0;
            r_tcount <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_length <= n_length;
            r_tsize  <= n_tsize;
            r_tcount <= n_tcount;
        end
    end

`ifndef SYNTHESIS
    // every terminal result except a non-final bad magic starts a new patch
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_cmd.kind == K_DONE || o_cmd.kind == K_TRUNC || o_cmd.kind == K_EARLY)
        |=> r_phase == PH_MAGIC && r_count == '0)
        else $error("parser did not restart after a terminal result");

    // literal data index stays inside the record
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count < r_length)
        else $error("data index past record length");
`endif

endmodule

// File: sv/ipsp_fifo.sv
`timescale 1ns / 1ps

module ipsp_fifo import ipsp_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_ipsp_cmd i_data,
    output logic      o_full,
    input  logic      i_pop,
    output t_ipsp_cmd o_data,
    output logic      o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_ipsp_cmd      r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: sv/ipsp_back.sv
`timescale 1ns / 1ps

module ipsp_back import ipsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_ipsp_cmd i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_ipsp_out o_result
);

    logic      r_valid;
    t_ipsp_out r_result, n_result;

    assign o_pop    = !i_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // write address wraps at 24 bits; index is zero for every other kind
    always_comb begin
        n_result.kind       = i_cmd.kind;
        n_result.address    = i_cmd.offset + {8'd0, i_cmd.index};
        n_result.run_length = i_cmd.run_length;
        n_result.data_value = i_cmd.data_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

`ifndef SYNTHESIS
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_result.kind <= K_EARLY)
        else $error("undefined result kind");
`endif

endmodule
